@@ design/tlsw_pkg.sv @@
package tlsw_pkg;

	// Frame constants of the link layer
	localparam logic [7:0] START_OCTET = 8'h68;
	localparam logic [7:0] LEN_CTRL_ONLY = 8'd4;
	localparam logic [7:0] LEN_NO_ADDRESS = 8'd6;
	localparam logic [15:0] U_STARTDT_ACT = 16'h0007;
	localparam logic [15:0] U_STARTDT_CON = 16'h000B;
	localparam logic [15:0] U_STOPDT_ACT = 16'h0013;
	localparam logic [15:0] U_STOPDT_CON = 16'h0023;
	localparam logic [15:0] U_TESTFR_ACT = 16'h0043;
	localparam logic [15:0] U_TESTFR_CON = 16'h0083;
	localparam logic [15:0] S_MARKER = 16'h0001;

	localparam int SEQ_W = 15;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 3;

	// Register indexes of the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STATION_ADDRESS = 3'd0,
		CFG_K_WINDOW = 3'd1,
		CFG_W_WINDOW = 3'd2,
		CFG_T2_SECONDS = 3'd3,
		CFG_T3_SECONDS = 3'd4,
		CFG_CHECK_SEQUENCE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] station_address;
		logic [SEQ_W-1:0] k_window;
		logic [SEQ_W-1:0] w_window;
		logic [7:0] t2_seconds;
		logic [7:0] t3_seconds;
		logic check_sequence;
	} cfg_t;

	// Input commands
	typedef enum logic [2:0] {
		EV_TICK = 3'd0,
		EV_FRAME = 3'd1,
		EV_SEND = 3'd2,
		EV_CONNECT = 3'd3,
		EV_DISCONNECT = 3'd4,
		EV_IGNORE = 3'd5
	} ev_t;

	// Classes of a received frame, settled in the front part
	typedef enum logic [3:0] {
		FC_BAD_START = 4'd0,
		FC_WRONG_ORIGIN = 4'd1,
		FC_STARTDT = 4'd2,
		FC_STOPDT_ACT = 4'd3,
		FC_STOPDT_CON = 4'd4,
		FC_TESTFR = 4'd5,
		FC_SUPERVISORY = 4'd6,
		FC_UNKNOWN_U = 4'd7,
		FC_INFO = 4'd8
	} fcls_t;

	typedef enum logic [2:0] {
		SK_NONE = 3'd0,
		SK_STARTDT_CON = 3'd1,
		SK_STOPDT_CON = 3'd2,
		SK_TESTFR_CON = 3'd3,
		SK_TESTFR_ACT = 3'd4,
		SK_S = 3'd5,
		SK_I = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_START = 3'd1,
		ST_WRONG_ORIGIN = 3'd2,
		ST_UNKNOWN_U = 3'd3,
		ST_BAD_NR = 3'd4,
		ST_NS_MISMATCH = 3'd5,
		ST_WINDOW_FULL = 3'd6
	} status_t;

	// Classified item that travels through the queue
	typedef struct packed {
		ev_t ev;
		fcls_t cls;
		logic [SEQ_W-1:0] ns;
		logic [SEQ_W-1:0] nr;
	} item_t;

	typedef struct packed {
		logic drop;
		status_t status;
		logic [15:0] w2;
		logic [15:0] w1;
		kind_t kind;
	} res_t;

endpackage

@@ design/telecontrol_link_sequence_window_top.sv @@
// Link sequence window controller, controlled-station side.
// Input channel s_*: one beat per event (tick, received frame control words,
// local send request, connect, disconnect). Output channel m_*: the frames to
// transmit, each with status and drop request; m_tlast marks the final beat
// that an event causes. An event causes zero to three output beats.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; the user must write registers only while no event is in flight; the
// block itself does not enforce this. The first output beat of an event
// passes the classifier register, then the queue, then the result buffer of
// the execution unit.
// Throughput: one event per cycle while events cause at most one beat each
// and the receiver does not stall; an event with several beats holds the
// execution unit, as the buffer hands out one beat per cycle with m_tready.
// Reset clears the sequence numbers, counters and timers, opens the send
// window and leaves the link down; configuration returns to its defaults.
// When the receiver stalls, results wait in the buffer, the two-entry queue
// and the classifier register fill, and s_tready then falls.
module telecontrol_link_sequence_window_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [tlsw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tlsw_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// cmd[2:0], start_octet[10:3], frame_length[18:11], first_control[34:19],
	// second_control[50:35], asdu_address[66:51], zero pad
	input logic [tlsw_pkg::IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// send_kind[2:0], send_first_word[18:3], send_second_word[34:19],
	// status[37:35], drop_link[38], zero pad
	output logic [tlsw_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic m_tlast
);
	import tlsw_pkg::*;

	cfg_t cfg_q;
	logic front_valid;
	logic front_ready;
	item_t front_item;
	logic head_valid;
	logic head_ready;
	item_t head_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.station_address <= 16'd0;
			cfg_q.k_window <= 15'd12;
			cfg_q.w_window <= 15'd8;
			cfg_q.t2_seconds <= 8'd10;
			cfg_q.t3_seconds <= 8'd20;
			cfg_q.check_sequence <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STATION_ADDRESS: cfg_q.station_address <= cfg_data;
				CFG_K_WINDOW: cfg_q.k_window <= cfg_data[SEQ_W-1:0];
				CFG_W_WINDOW: cfg_q.w_window <= cfg_data[SEQ_W-1:0];
				CFG_T2_SECONDS: cfg_q.t2_seconds <= cfg_data[7:0];
				CFG_T3_SECONDS: cfg_q.t3_seconds <= cfg_data[7:0];
				CFG_CHECK_SEQUENCE: cfg_q.check_sequence <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tlsw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.item_valid(front_valid),
		.item_ready(front_ready),
		.item(front_item)
	);

	tlsw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(front_valid),
		.wr_ready(front_ready),
		.wr_item(front_item),
		.rd_valid(head_valid),
		.rd_ready(head_ready),
		.rd_item(head_item)
	);

	tlsw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(head_valid),
		.item_ready(head_ready),
		.item(head_item),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

@@ design/tlsw_front.sv @@
module tlsw_front (
	input logic clk,
	input logic arst_n,
	input tlsw_pkg::cfg_t cfg,
	input logic s_tvalid,
	output logic s_tready,
	// cmd, start_octet, frame_length, first_control, second_control, asdu_address
	input logic [tlsw_pkg::IN_DATA_W-1:0] s_tdata,
	output logic item_valid,
	input logic item_ready,
	output tlsw_pkg::item_t item
);
	import tlsw_pkg::*;

	logic [2:0] cmd;
	logic [7:0] start_octet;
	logic [7:0] frame_length;
	logic [15:0] first_control;
	logic [15:0] second_control;
	logic [15:0] asdu_address;
	item_t cls_item;
	logic valid_s1;
	item_t item_s1;

	assign cmd = s_tdata[2:0];
	assign start_octet = s_tdata[10:3];
	assign frame_length = s_tdata[18:11];
	assign first_control = s_tdata[34:19];
	assign second_control = s_tdata[50:35];
	assign asdu_address = s_tdata[66:51];

	// Decode the command and sort a received frame into its class.
	always_comb begin
		cls_item.ns = first_control[SEQ_W:1];
		cls_item.nr = second_control[SEQ_W:1];
		case (cmd)
			EV_TICK: cls_item.ev = EV_TICK;
			EV_FRAME: cls_item.ev = EV_FRAME;
			EV_SEND: cls_item.ev = EV_SEND;
			EV_CONNECT: cls_item.ev = EV_CONNECT;
			EV_DISCONNECT: cls_item.ev = EV_DISCONNECT;
			default: cls_item.ev = EV_IGNORE;
		endcase
		if (start_octet != START_OCTET || frame_length < LEN_CTRL_ONLY) begin
			cls_item.cls = FC_BAD_START;
		end else if (frame_length > LEN_NO_ADDRESS && asdu_address != cfg.station_address) begin
			cls_item.cls = FC_WRONG_ORIGIN;
		end else if (frame_length != LEN_CTRL_ONLY) begin
			cls_item.cls = FC_INFO;
		end else begin
			case (first_control)
				U_STARTDT_ACT: cls_item.cls = FC_STARTDT;
				U_STOPDT_ACT: cls_item.cls = FC_STOPDT_ACT;
				U_STOPDT_CON: cls_item.cls = FC_STOPDT_CON;
				U_TESTFR_ACT: cls_item.cls = FC_TESTFR;
				S_MARKER: cls_item.cls = FC_SUPERVISORY;
				default: cls_item.cls = FC_UNKNOWN_U;
			endcase
		end
	end

	assign s_tready = !valid_s1 || item_ready;

	// One register stage holds the classified beat until the queue takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= cls_item;
		end
	end

	assign item_valid = valid_s1;
	assign item = item_s1;

endmodule

@@ design/tlsw_queue.sv @@
module tlsw_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input tlsw_pkg::item_t wr_item,
	output logic rd_valid,
	input logic rd_ready,
	output tlsw_pkg::item_t rd_item
);
	import tlsw_pkg::*;

	item_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign wr_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_item = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond its depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |=> (count_q <= QCNT_W'(1)))
		else $error("queue count jumped from empty");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

endmodule

@@ design/tlsw_back.sv @@
module tlsw_back (
	input logic clk,
	input logic arst_n,
	input tlsw_pkg::cfg_t cfg,
	input logic item_valid,
	output logic item_ready,
	input tlsw_pkg::item_t item,
	output logic m_tvalid,
	input logic m_tready,
	// send_kind, send_first_word, send_second_word, status, drop_link, zero pad
	output logic [tlsw_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic m_tlast
);
	import tlsw_pkg::*;

	// Link state
	logic [SEQ_W-1:0] send_seq_q;
	logic [SEQ_W-1:0] recv_seq_q;
	logic [SEQ_W-1:0] unacked_q;
	logic send_allowed_q;
	logic [SEQ_W-1:0] rcv_count_q;
	logic ack_idle_q;
	logic [7:0] ack_cnt_q;
	logic [7:0] idle_timer_q;
	logic link_up_q;

	// Result buffer
	res_t res_q [3];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;

	// Next state
	logic [SEQ_W-1:0] send_seq_d;
	logic [SEQ_W-1:0] recv_seq_d;
	logic [SEQ_W-1:0] unacked_d;
	logic send_allowed_d;
	logic [SEQ_W-1:0] rcv_count_d;
	logic ack_idle_d;
	logic [7:0] ack_cnt_d;
	logic [7:0] idle_timer_d;
	logic link_up_d;
	res_t res0;
	res_t res1;
	res_t res2;
	logic [1:0] cnt_d;

	logic [SEQ_W-1:0] unacked_ack;
	logic ack_ok;
	logic accepted;
	logic s_t2;
	logic s_w;
	logic [SEQ_W-1:0] rcv_inc;
	logic [SEQ_W-1:0] unacked_inc;
	logic [7:0] ack_dec;
	logic [7:0] idle_dec;
	res_t s_frame;
	res_t testfr_frame;
	logic final_beat;
	logic load;

	assign final_beat = m_tvalid && m_tready && (idx_q == cnt_q - 2'd1);
	assign item_ready = (cnt_q == 2'd0) || final_beat;
	assign load = item_valid && item_ready;

	assign unacked_ack = send_seq_q - item.nr;
	assign ack_ok = send_seq_q >= item.nr;
	assign unacked_inc = unacked_q + 1'b1;
	assign ack_dec = ack_cnt_q - 8'd1;
	assign idle_dec = idle_timer_q - 8'd1;

	// Work out the results and the next link state for the item at the head.
	always_comb begin
		send_seq_d = send_seq_q;
		recv_seq_d = recv_seq_q;
		unacked_d = unacked_q;
		send_allowed_d = send_allowed_q;
		rcv_count_d = rcv_count_q;
		ack_idle_d = ack_idle_q;
		ack_cnt_d = ack_cnt_q;
		idle_timer_d = idle_timer_q;
		link_up_d = link_up_q;
		res0 = '0;
		res1 = '0;
		res2 = '0;
		cnt_d = 2'd0;
		accepted = 1'b0;
		s_t2 = 1'b0;
		s_w = 1'b0;
		rcv_inc = '0;
		s_frame = '0;
		testfr_frame = '0;

		case (item.ev)
			EV_FRAME: begin
				cnt_d = 2'd1;
				case (item.cls)
					FC_BAD_START: res0.status = ST_NO_START;
					FC_WRONG_ORIGIN: res0.status = ST_WRONG_ORIGIN;
					FC_STARTDT: begin
						res0.kind = SK_STARTDT_CON;
						res0.w1 = U_STARTDT_CON;
						accepted = 1'b1;
					end
					FC_STOPDT_ACT: begin
						res0.kind = SK_STOPDT_CON;
						res0.w1 = U_STOPDT_CON;
						accepted = 1'b1;
					end
					FC_STOPDT_CON: accepted = 1'b1;
					FC_TESTFR: begin
						res0.kind = SK_TESTFR_CON;
						res0.w1 = U_TESTFR_CON;
						accepted = 1'b1;
					end
					FC_UNKNOWN_U: begin
						res0.status = ST_UNKNOWN_U;
						accepted = 1'b1;
					end
					FC_SUPERVISORY: begin
						if (ack_ok) begin
							accepted = 1'b1;
						end else begin
							res0.status = ST_BAD_NR;
						end
					end
					FC_INFO: begin
						if (item.ns != recv_seq_q) begin
							res0.status = ST_NS_MISMATCH;
							res0.drop = cfg.check_sequence;
						end else begin
							recv_seq_d = recv_seq_q + 1'b1;
						end
						// A bad N(R) overrides a tolerated sequence mismatch.
						if (!res0.drop) begin
							if (ack_ok) begin
								accepted = 1'b1;
							end else begin
								res0.status = ST_BAD_NR;
							end
						end
					end
					default: res0.status = ST_NO_START;
				endcase

				// Acknowledge handling for S and I frames that pass the N(R) check
				if (accepted && (item.cls == FC_SUPERVISORY || item.cls == FC_INFO)) begin
					unacked_d = unacked_ack;
					if (unacked_ack < cfg.k_window) begin
						send_allowed_d = 1'b1;
					end
				end

				// Timer and receive-window step of an accepted frame
				if (accepted) begin
					if (ack_idle_q) begin
						ack_idle_d = 1'b0;
						ack_cnt_d = cfg.t2_seconds;
					end else if (ack_cnt_q == 8'd0) begin
						ack_idle_d = 1'b1;
						s_t2 = 1'b1;
					end else begin
						ack_cnt_d = ack_dec;
					end
					idle_timer_d = cfg.t3_seconds;
					rcv_inc = rcv_count_q + 1'b1;
					if (rcv_inc == cfg.w_window) begin
						s_w = 1'b1;
						rcv_count_d = '0;
					end else begin
						rcv_count_d = rcv_inc;
					end
					s_frame.kind = SK_S;
					s_frame.w1 = S_MARKER;
					s_frame.w2 = {recv_seq_d, 1'b0};
					res1 = s_frame;
					res2 = s_frame;
					cnt_d = 2'd1 + {1'b0, s_t2} + {1'b0, s_w};
				end
			end
			EV_TICK: begin
				if (link_up_q) begin
					if (!ack_idle_q && ack_cnt_q != 8'd0) begin
						ack_cnt_d = ack_dec;
						if (ack_dec == 8'd0) begin
							ack_idle_d = 1'b1;
							s_t2 = 1'b1;
						end
					end
					if (idle_timer_q != 8'd0) begin
						idle_timer_d = idle_dec;
						s_w = idle_dec == 8'd0;
					end
					s_frame.kind = SK_S;
					s_frame.w1 = S_MARKER;
					s_frame.w2 = {recv_seq_q, 1'b0};
					testfr_frame.kind = SK_TESTFR_ACT;
					testfr_frame.w1 = U_TESTFR_ACT;
					res0 = s_t2 ? s_frame : testfr_frame;
					res1 = testfr_frame;
					cnt_d = {1'b0, s_t2} + {1'b0, s_w};
				end
			end
			EV_SEND: begin
				cnt_d = 2'd1;
				if (send_allowed_q) begin
					res0.kind = SK_I;
					res0.w1 = {send_seq_q, 1'b0};
					res0.w2 = {recv_seq_q, 1'b0};
					send_seq_d = send_seq_q + 1'b1;
					unacked_d = unacked_inc;
					if (unacked_inc >= cfg.k_window) begin
						send_allowed_d = 1'b0;
					end
				end else begin
					res0.status = ST_WINDOW_FULL;
				end
			end
			EV_CONNECT: begin
				send_seq_d = '0;
				recv_seq_d = '0;
				link_up_d = 1'b1;
			end
			EV_DISCONNECT: link_up_d = 1'b0;
			default: cnt_d = 2'd0;
		endcase
	end

	// Link state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_seq_q <= '0;
			recv_seq_q <= '0;
			unacked_q <= '0;
			send_allowed_q <= 1'b1;
			rcv_count_q <= '0;
			ack_idle_q <= 1'b1;
			ack_cnt_q <= '0;
			idle_timer_q <= '0;
			link_up_q <= 1'b0;
		end else if (load) begin
			send_seq_q <= send_seq_d;
			recv_seq_q <= recv_seq_d;
			unacked_q <= unacked_d;
			send_allowed_q <= send_allowed_d;
			rcv_count_q <= rcv_count_d;
			ack_idle_q <= ack_idle_d;
			ack_cnt_q <= ack_cnt_d;
			idle_timer_q <= idle_timer_d;
			link_up_q <= link_up_d;
		end
	end

	// Buffer control: one beat of the loaded results a cycle while m_tready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= cnt_d;
			idx_q <= 2'd0;
		end else if (final_beat) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q[0] <= res0;
			res_q[1] <= res1;
			res_q[2] <= res2;
		end
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata = {1'b0, res_q[idx_q]};
	assign m_tlast = idx_q == cnt_q - 2'd1;

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (idx_q < cnt_q))
		else $error("result index beyond the loaded result count");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 2'd0 || final_beat))
		else $error("new item loaded over undelivered results");
	a_connect_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && item.ev == EV_CONNECT) |=> (link_up_q && send_seq_q == '0 && recv_seq_q == '0))
		else $error("connect did not restart the sequence numbers");
	a_full_window_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(load && item.ev == EV_SEND && !send_allowed_q) |=> (send_seq_q == $past(send_seq_q)))
		else $error("I frame counted while the window was closed");

endmodule

@@ tb/sv/tb_telecontrol_link_sequence_window_top.sv @@
module tb_telecontrol_link_sequence_window_top;
	import tlsw_pkg::*;

	// One event as it travels on the input stream.
	typedef struct packed {
		logic [15:0] asdu_addr;
		logic [15:0] ctrl2;
		logic [15:0] ctrl1;
		logic [7:0] frame_len;
		logic [7:0] start_oct;
		logic [2:0] cmd;
	} link_event_t;

	// One frame that the link layer is to transmit.
	typedef struct {
		kind_t kind;
		logic [15:0] word1;
		logic [15:0] word2;
		status_t status;
		logic drop;
		logic last;
	} link_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;

	telecontrol_link_sequence_window_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// Settings as the block should hold them.
	logic [15:0] st_addr = 16'h0000;
	logic [14:0] k_win = 15'd12;
	logic [14:0] w_win = 15'd8;
	logic [7:0] t2_sec = 8'd10;
	logic [7:0] t3_sec = 8'd20;
	logic chk_seq = 1'b1;

	// Link state as the block should hold it.
	logic [14:0] snd_seq = '0;
	logic [14:0] rcv_seq = '0;
	logic [14:0] unacked = '0;
	logic snd_open = 1'b1;
	logic [14:0] rcv_count = '0;
	int ack_cnt = -1;
	logic [7:0] idle_cnt = '0;
	logic link_is_up = 1'b0;

	link_reply_t reply_batch[$];
	link_reply_t expected_frames[$];

	int mismatches = 0;
	int burst_left = 0;
	bit tx_no_gaps = 1'b0;
	bit rx_free = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int rx_run = 0;
	bit rx_on = 1'b1;

	function automatic void add_reply(kind_t kind, logic [15:0] w1, logic [15:0] w2,
			status_t st, logic drop);
		link_reply_t r;
		r.kind = kind;
		r.word1 = w1;
		r.word2 = w2;
		r.status = st;
		r.drop = drop;
		r.last = 1'b0;
		reply_batch.push_back(r);
	endfunction

	// Acknowledge check: N(R) may not run ahead of the send sequence.
	function automatic bit take_ack(logic [15:0] w2);
		logic [14:0] nr;
		nr = w2[15:1];
		if (snd_seq < nr)
			return 1'b0;
		unacked = snd_seq - nr;
		if (unacked < k_win)
			snd_open = 1'b1;
		return 1'b1;
	endfunction

	function automatic void predict_tick();
		if (link_is_up) begin
			if (ack_cnt > 0) begin
				ack_cnt--;
				if (ack_cnt == 0) begin
					add_reply(SK_S, S_MARKER, {rcv_seq, 1'b0}, ST_OK, 1'b0);
					ack_cnt = -1;
				end
			end
			if (idle_cnt > 0) begin
				idle_cnt--;
				if (idle_cnt == 0)
					add_reply(SK_TESTFR_ACT, U_TESTFR_ACT, 16'h0000, ST_OK, 1'b0);
			end
		end
	endfunction

	function automatic void predict_frame(link_event_t e);
		kind_t kind;
		logic [15:0] rw1;
		status_t st;
		kind = SK_NONE;
		rw1 = 16'h0000;
		st = ST_OK;
		if (e.start_oct != START_OCTET || e.frame_len < LEN_CTRL_ONLY) begin
			add_reply(SK_NONE, 16'h0000, 16'h0000, ST_NO_START, 1'b0);
			return;
		end
		if (e.frame_len > LEN_NO_ADDRESS && e.asdu_addr != st_addr) begin
			add_reply(SK_NONE, 16'h0000, 16'h0000, ST_WRONG_ORIGIN, 1'b0);
			return;
		end
		if (e.frame_len == LEN_CTRL_ONLY) begin
			case (e.ctrl1)
				U_STARTDT_ACT: begin
					kind = SK_STARTDT_CON;
					rw1 = U_STARTDT_CON;
				end
				U_STOPDT_ACT: begin
					kind = SK_STOPDT_CON;
					rw1 = U_STOPDT_CON;
				end
				U_STOPDT_CON: ;
				U_TESTFR_ACT: begin
					kind = SK_TESTFR_CON;
					rw1 = U_TESTFR_CON;
				end
				S_MARKER: begin
					if (!take_ack(e.ctrl2)) begin
						add_reply(SK_NONE, 16'h0000, 16'h0000, ST_BAD_NR, 1'b0);
						return;
					end
				end
				default: st = ST_UNKNOWN_U;
			endcase
		end else begin
			// Information frame: N(S) must match the receive sequence.
			if (e.ctrl1[15:1] != rcv_seq) begin
				st = ST_NS_MISMATCH;
				if (chk_seq) begin
					add_reply(SK_NONE, 16'h0000, 16'h0000, ST_NS_MISMATCH, 1'b1);
					return;
				end
			end else begin
				rcv_seq = rcv_seq + 1'b1;
			end
			if (!take_ack(e.ctrl2)) begin
				add_reply(SK_NONE, 16'h0000, 16'h0000, ST_BAD_NR, 1'b0);
				return;
			end
		end
		add_reply(kind, rw1, 16'h0000, st, 1'b0);

		// The t2 and t3 timers and the w count step on every accepted frame.
		if (ack_cnt < 0) begin
			ack_cnt = t2_sec;
		end else if (ack_cnt == 0) begin
			ack_cnt = -1;
			add_reply(SK_S, S_MARKER, {rcv_seq, 1'b0}, ST_OK, 1'b0);
		end else begin
			ack_cnt--;
		end
		idle_cnt = t3_sec;
		rcv_count = rcv_count + 1'b1;
		if (rcv_count == w_win) begin
			add_reply(SK_S, S_MARKER, {rcv_seq, 1'b0}, ST_OK, 1'b0);
			rcv_count = '0;
		end
	endfunction

	// Works out the frames that one accepted event causes and queues them.
	function automatic void predict_link_response(link_event_t e);
		reply_batch.delete();
		case (e.cmd)
			EV_TICK: predict_tick();
			EV_FRAME: predict_frame(e);
			EV_SEND: begin
				if (snd_open) begin
					add_reply(SK_I, {snd_seq, 1'b0}, {rcv_seq, 1'b0}, ST_OK, 1'b0);
					snd_seq = snd_seq + 1'b1;
					unacked = unacked + 1'b1;
					if (unacked >= k_win)
						snd_open = 1'b0;
				end else begin
					add_reply(SK_NONE, 16'h0000, 16'h0000, ST_WINDOW_FULL, 1'b0);
				end
			end
			EV_CONNECT: begin
				snd_seq = '0;
				rcv_seq = '0;
				link_is_up = 1'b1;
			end
			EV_DISCONNECT: link_is_up = 1'b0;
			default: ;
		endcase
		if (reply_batch.size() > 0)
			reply_batch[reply_batch.size()-1].last = 1'b1;
		foreach (reply_batch[i])
			expected_frames.push_back(reply_batch[i]);
	endfunction

	function automatic link_event_t plain(logic [2:0] cmd);
		link_event_t e;
		e = '0;
		e.cmd = cmd;
		return e;
	endfunction

	function automatic link_event_t frame(logic [7:0] so, logic [7:0] len, logic [15:0] w1,
			logic [15:0] w2, logic [15:0] ca);
		link_event_t e;
		e.cmd = EV_FRAME;
		e.start_oct = so;
		e.frame_len = len;
		e.ctrl1 = w1;
		e.ctrl2 = w2;
		e.asdu_addr = ca;
		return e;
	endfunction

	// Mostly a valid N(R), now and then one that runs ahead of the send sequence.
	function automatic logic [14:0] pick_nr();
		if ($urandom_range(0, 7) == 0)
			return 15'($urandom);
		if ($urandom_range(0, 2) == 0)
			return snd_seq;
		return 15'($urandom_range(0, snd_seq));
	endfunction

	function automatic link_event_t random_event();
		link_event_t e;
		int pick;
		e = '0;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			e.cmd = EV_TICK;
		end else if (pick < 50) begin
			// Information frame, mostly in sequence and from the right station.
			e.cmd = EV_FRAME;
			e.start_oct = START_OCTET;
			e.frame_len = ($urandom_range(0, 3) == 0) ? LEN_NO_ADDRESS
				: 8'($urandom_range(7, 255));
			e.ctrl1 = {(($urandom_range(0, 9) != 0) ? rcv_seq : 15'($urandom)),
				1'($urandom)};
			e.ctrl2 = {pick_nr(), 1'($urandom)};
			e.asdu_addr = ($urandom_range(0, 9) != 0) ? st_addr : 16'($urandom);
		end else if (pick < 65) begin
			// Control-only frame: U codes and S acknowledges.
			e.cmd = EV_FRAME;
			e.start_oct = START_OCTET;
			e.frame_len = LEN_CTRL_ONLY;
			case ($urandom_range(0, 6))
				0: e.ctrl1 = U_STARTDT_ACT;
				1: e.ctrl1 = U_STOPDT_ACT;
				2: e.ctrl1 = U_STOPDT_CON;
				3: e.ctrl1 = U_TESTFR_ACT;
				4, 5: e.ctrl1 = S_MARKER;
				default: e.ctrl1 = 16'($urandom);
			endcase
			e.ctrl2 = {pick_nr(), 1'($urandom)};
			e.asdu_addr = 16'($urandom);
		end else if (pick < 85) begin
			e.cmd = EV_SEND;
		end else if (pick < 90) begin
			e.cmd = EV_CONNECT;
		end else if (pick < 93) begin
			e.cmd = EV_DISCONNECT;
		end else begin
			// Noise: any command with arbitrary content.
			e.cmd = 3'($urandom);
			e.start_oct = $urandom_range(0, 1) ? START_OCTET : 8'($urandom);
			e.frame_len = 8'($urandom);
			e.ctrl1 = 16'($urandom);
			e.ctrl2 = 16'($urandom);
			e.asdu_addr = 16'($urandom);
		end
		return e;
	endfunction

	// Offers one event in bursts with random gaps and waits for its beat.
	task automatic send_event(link_event_t e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = tx_no_gaps ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, e};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_link_response(e);
	endtask

	// Stops offering and waits until every expected frame has come out.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_STATION_ADDRESS: st_addr = value;
			CFG_K_WINDOW: k_win = value[14:0];
			CFG_W_WINDOW: w_win = value[14:0];
			CFG_T2_SECONDS: t2_sec = value[7:0];
			CFG_T3_SECONDS: t3_sec = value[7:0];
			CFG_CHECK_SEQUENCE: chk_seq = value[0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] addr, logic [14:0] k, logic [14:0] w,
			logic [7:0] t2, logic [7:0] t3, logic chk);
		write_reg(CFG_STATION_ADDRESS, addr);
		write_reg(CFG_K_WINDOW, {1'b0, k});
		write_reg(CFG_W_WINDOW, {1'b0, w});
		write_reg(CFG_T2_SECONDS, {8'h00, t2});
		write_reg(CFG_T3_SECONDS, {8'h00, t3});
		write_reg(CFG_CHECK_SEQUENCE, {15'h0000, chk});
	endtask

	// Default settings: every command, each U code and each frame error.
	task automatic test_directed_events();
		send_event(plain(EV_TICK));
		for (int c = EV_IGNORE; c < 8; c++)
			send_event(plain(3'(c)));
		send_event(plain(EV_CONNECT));
		send_event(frame(8'h00, LEN_CTRL_ONLY, U_STARTDT_ACT, 16'h0000, 16'h0000));
		send_event(frame(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_event(frame(START_OCTET, 8'(LEN_CTRL_ONLY - 8'd1), U_STARTDT_ACT, 16'h0, 16'h0));
		send_event(frame(START_OCTET, 8'h00, 16'h0000, 16'h0000, 16'h0000));
		send_event(frame(START_OCTET, 8'hFF, 16'h0000, 16'h0000, 16'hFFFF));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, U_STARTDT_ACT, 16'h0, 16'h0));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, U_STOPDT_ACT, 16'h0, 16'h0));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, U_STOPDT_CON, 16'h0, 16'h0));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, U_TESTFR_ACT, 16'h0, 16'h0));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, 16'hFFFF, 16'h0, 16'h0));
		send_event(plain(EV_SEND));
		send_event(plain(EV_SEND));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, S_MARKER, 16'h0002, 16'h0));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, S_MARKER, 16'hFFFF, 16'h0));
		send_event(frame(START_OCTET, LEN_NO_ADDRESS, {rcv_seq, 1'b0}, 16'h0, 16'hFFFF));
		send_event(frame(START_OCTET, 8'd14, {rcv_seq, 1'b1}, {snd_seq, 1'b0}, st_addr));
		// Out-of-sequence N(S) drops the link while the check is on.
		send_event(frame(START_OCTET, 8'd14, {rcv_seq + 15'd5, 1'b0}, 16'h0, st_addr));
		// In-sequence N(S) but N(R) ahead of the send sequence.
		send_event(frame(START_OCTET, LEN_NO_ADDRESS, {rcv_seq, 1'b0},
			{snd_seq + 15'd3, 1'b0}, 16'h0));
		send_event(plain(EV_TICK));
		send_event(plain(EV_TICK));
		send_event(plain(EV_DISCONNECT));
		send_event(plain(EV_TICK));
		wait_drained();
	endtask

	// Settings at their extremes, the tightest first and then the widest.
	task automatic test_extreme_settings();
		set_config(16'hFFFF, 15'd1, 15'd1, 8'd1, 8'd1, 1'b0);
		send_event(plain(EV_CONNECT));
		send_event(plain(EV_SEND));
		send_event(plain(EV_SEND));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, S_MARKER, {snd_seq, 1'b0}, 16'h0));
		send_event(plain(EV_SEND));
		send_event(frame(START_OCTET, 8'hFF, {rcv_seq, 1'b0}, {snd_seq, 1'b0}, 16'hFFFF));
		send_event(frame(START_OCTET, 8'hFF, {rcv_seq + 15'd1, 1'b0}, 16'h0, 16'hFFFF));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, U_STARTDT_ACT, 16'h0, 16'h0));
		send_event(plain(EV_TICK));
		send_event(plain(EV_TICK));
		send_event(frame(START_OCTET, LEN_CTRL_ONLY, U_TESTFR_ACT, 16'h0, 16'h0));
		send_event(plain(EV_TICK));
		send_event(frame(START_OCTET, 8'd7, {rcv_seq, 1'b0}, 16'h0, 16'h0000));
		wait_drained();

		set_config(16'($urandom), 15'h7FFF, 15'h7FFF, 8'hFF, 8'hFF, 1'b1);
		send_event(plain(EV_CONNECT));
		repeat (12) send_event(random_event());
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while events keep coming.
	task automatic test_receiver_holdoff();
		rx_free = 1'b0;
		tx_no_gaps = 1'b1;
		set_config(st_addr, 15'h7FFF, w_win, t2_sec, t3_sec, chk_seq);
		send_event(plain(EV_CONNECT));
		hold_request = 400;
		for (int i = 0; i < 8; i++) begin
			send_event(plain(EV_SEND));
			send_event(frame(START_OCTET, LEN_CTRL_ONLY, U_TESTFR_ACT, 16'h0, 16'h0));
		end
		wait_drained();
		tx_no_gaps = 1'b0;
	endtask

	// Random traffic over several random settings, mostly well formed.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			rx_free = (phase == 0);
			tx_no_gaps = (phase == 0) || ($urandom_range(0, 3) == 0);
			set_config(($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
				($urandom_range(0, 4) == 0) ? 15'h7FFF : 15'($urandom_range(1, 6)),
				15'($urandom_range(1, 10)),
				($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
					: 8'($urandom_range(1, 6)),
				($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
					: 8'($urandom_range(1, 6)),
				1'($urandom));
			send_event(plain(EV_CONNECT));
			repeat (10) send_event(random_event());
			// Sender pauses here until every expected frame has come out.
			wait_drained();
		end
		rx_free = 1'b0;
	endtask

	// Receiver: a long hold-off on request, otherwise its own stall pattern.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_free) begin
			m_tready <= 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_on = ($urandom_range(0, 3) != 0);
				rx_run = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 5);
			end
			rx_run--;
			m_tready <= rx_on;
		end
	end

	// Each output beat is checked against the oldest expected frame.
	always @(posedge clk) begin
		link_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: data %h last %b", m_tdata, m_tlast);
			end else begin
				want = expected_frames.pop_front();
				if (m_tdata[2:0] !== want.kind || m_tdata[18:3] !== want.word1 ||
						m_tdata[34:19] !== want.word2 || m_tdata[37:35] !== want.status ||
						m_tdata[38] !== want.drop || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: kind %0d/%0d w1 %h/%h w2 %h/%h",
							want.kind, m_tdata[2:0], want.word1, m_tdata[18:3],
							want.word2, m_tdata[34:19]);
						$display(" status %0d/%0d drop %b/%b last %b/%b (expected/actual)",
							want.status, m_tdata[37:35], want.drop, m_tdata[38],
							want.last, m_tlast);
					end
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_events();
		test_extreme_settings();
		test_receiver_holdoff();
		test_random_traffic();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("[telecontrol_link_sequence_window_top] OK");
		end else begin
			$display("[telecontrol_link_sequence_window_top] ERROR");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("[telecontrol_link_sequence_window_top] ERROR");
		$finish;
	end

endmodule
